@@ rtl/core/dmwbc_pkg.sv @@
// ============================================================================
// dmwbc_pkg
// Request and result types, request codes, result codes and controller states
// shared by the direct-mapped write-back cache.
// ============================================================================
package dmwbc_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    // Result kinds.
    localparam logic [2:0] RK_READ  = 3'd0;
    localparam logic [2:0] RK_WRITE = 3'd1;
    localparam logic [2:0] RK_WB    = 3'd2;
    localparam logic [2:0] RK_FILL  = 3'd3;
    localparam logic [2:0] RK_BAD   = 3'd4;

    // One incoming request.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] word;
    } t_req;

    // One outgoing result.
    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] result_address;
        logic [31:0] result_word;
        logic        hit;
        logic        last;
    } t_res;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB,
        ST_FREQ,
        ST_FIN,
        ST_RESP
    } t_state;

endpackage

@@ rtl/core/dmwbc_ram.sv @@
// ============================================================================
// dmwbc_ram
// Simple dual-port synchronous RAM: one write port, one read port, with the
// read data registered.
// ============================================================================
module dmwbc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/direct_mapped_writeback_cache.sv @@
// ============================================================================
// direct_mapped_writeback_cache
// Direct-mapped, write-back, write-allocate cache. Line state (tag, valid,
// dirty) lives in a tag RAM, line words in a data RAM; a controller reads,
// checks and writes both back, and streams write-back beats and fill words.
// ============================================================================
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      i_req   (kind, address, word)
// result    out        o_res_strobe, one cycle   o_res   (kind, address, word,
//                                                         hit, last)
//
// A read or write hit keeps busy high through the lookup state and registers
// its result out of that state; the next request is taken only after it.
// A miss adds WORDS_PER_LINE write-back beats (one per cycle, paced by the
// data RAM read port) when the victim is dirty, then the fill request. Fill
// words are taken one per cycle; after the last one busy stays high through
// the finish state, and for a read through the response state too. After reset
// a clearing pass sweeps every tag entry with busy high. The receiver cannot
// stall results. NUM_SETS and WORDS_PER_LINE must be powers of two; the block does not check.
module direct_mapped_writeback_cache #(
    parameter int NUM_SETS       = 1024,
    parameter int WORDS_PER_LINE = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  dmwbc_pkg::t_req i_req,
    output logic           busy,
    output logic           o_res_strobe,
    output dmwbc_pkg::t_res o_res
);

    localparam int OFF_BITS   = $clog2(WORDS_PER_LINE);
    localparam int IDX_BITS   = $clog2(NUM_SETS);
    localparam int TAG_BITS   = 30 - OFF_BITS - IDX_BITS;
    localparam int DADDR_BITS = IDX_BITS + OFF_BITS;
    localparam int TENT_BITS  = TAG_BITS + 2;

    localparam logic [OFF_BITS-1:0] OFF_LAST = OFF_BITS'(WORDS_PER_LINE - 1);
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(NUM_SETS - 1);

    // Controller registers.
    dmwbc_pkg::t_state r_state, n_state;
    logic                r_pend, n_pend;
    logic                r_acc_write, n_acc_write;
    logic [31:0]         r_acc_addr, n_acc_addr;
    logic [31:0]         r_acc_word, n_acc_word;
    logic [OFF_BITS-1:0] r_cnt, n_cnt;
    logic [IDX_BITS-1:0] r_clr, n_clr;
    logic [TAG_BITS-1:0] r_vtag, n_vtag;
    logic                r_strobe, n_strobe;
    dmwbc_pkg::t_res     r_res, n_res;

    // RAM ports.
    logic                  tag_we;
    logic [IDX_BITS-1:0]   tag_waddr, tag_raddr;
    logic [TENT_BITS-1:0]  tag_wdata, tag_rdata;
    logic                  dat_we;
    logic [DADDR_BITS-1:0] dat_waddr, dat_raddr;
    logic [31:0]           dat_wdata, dat_rdata;

    // Address fields of the incoming and the held access.
    logic [IDX_BITS-1:0] in_idx, acc_idx;
    logic [OFF_BITS-1:0] in_off, acc_off;
    logic [TAG_BITS-1:0] acc_tag;
    logic                ent_valid, ent_dirty;
    logic [TAG_BITS-1:0] ent_tag;
    logic                lk_hit;

    assign in_idx  = i_req.address[2+OFF_BITS +: IDX_BITS];
    assign in_off  = i_req.address[2 +: OFF_BITS];
    assign acc_idx = r_acc_addr[2+OFF_BITS +: IDX_BITS];
    assign acc_off = r_acc_addr[2 +: OFF_BITS];
    assign acc_tag = r_acc_addr[31 -: TAG_BITS];

    // Tag entry layout: valid, dirty, tag.
    assign ent_valid = tag_rdata[TENT_BITS-1];
    assign ent_dirty = tag_rdata[TENT_BITS-2];
    assign ent_tag   = tag_rdata[TAG_BITS-1:0];
    assign lk_hit    = ent_valid && (ent_tag == acc_tag);

    dmwbc_ram #(
        .DEPTH (NUM_SETS),
        .WIDTH (TENT_BITS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    dmwbc_ram #(
        .DEPTH (NUM_SETS * WORDS_PER_LINE),
        .WIDTH (32)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_raddr (dat_raddr),
        .o_rdata (dat_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dmwbc_pkg::ST_CLEAR: begin
                if (r_clr == IDX_LAST) begin
                    n_state = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_pend) begin
                        if (i_req.kind == dmwbc_pkg::KIND_FILL && r_cnt == OFF_LAST) begin
                            n_state = dmwbc_pkg::ST_FIN;
                        end
                    end else if (i_req.kind == dmwbc_pkg::KIND_READ ||
                                 i_req.kind == dmwbc_pkg::KIND_WRITE) begin
                        n_state = dmwbc_pkg::ST_LOOKUP;
                    end
                end
            end
            dmwbc_pkg::ST_LOOKUP: begin
                if (!lk_hit && ent_valid && ent_dirty) begin
                    n_state = dmwbc_pkg::ST_WB;
                end else begin
                    n_state = dmwbc_pkg::ST_IDLE;
                end
            end
            dmwbc_pkg::ST_WB: begin
                if (r_cnt == OFF_LAST) begin
                    n_state = dmwbc_pkg::ST_FREQ;
                end
            end
            dmwbc_pkg::ST_FREQ: begin
                n_state = dmwbc_pkg::ST_IDLE;
            end
            dmwbc_pkg::ST_FIN: begin
                n_state = r_acc_write ? dmwbc_pkg::ST_IDLE : dmwbc_pkg::ST_RESP;
            end
            dmwbc_pkg::ST_RESP: begin
                n_state = dmwbc_pkg::ST_IDLE;
            end
            default: begin
                n_state = dmwbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM controls and results.
    always_comb begin
        n_pend      = r_pend;
        n_acc_write = r_acc_write;
        n_acc_addr  = r_acc_addr;
        n_acc_word  = r_acc_word;
        n_cnt       = r_cnt;
        n_clr       = r_clr;
        n_vtag      = r_vtag;
        n_strobe    = 1'b0;
        n_res       = '0;
        tag_we      = 1'b0;
        tag_waddr   = acc_idx;
        tag_wdata   = '0;
        tag_raddr   = in_idx;
        dat_we      = 1'b0;
        dat_waddr   = {acc_idx, acc_off};
        dat_wdata   = r_acc_word;
        dat_raddr   = {in_idx, in_off};
        case (r_state)
            // Sweep the tag RAM to invalid, clean lines.
            dmwbc_pkg::ST_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = r_clr;
                n_clr     = r_clr + IDX_BITS'(1);
            end
            // Take requests; fill words load the pending line in order.
            dmwbc_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_pend) begin
                        if (i_req.kind == dmwbc_pkg::KIND_FILL) begin
                            dat_we    = 1'b1;
                            dat_waddr = {acc_idx, r_cnt};
                            dat_wdata = i_req.word;
                            n_cnt     = r_cnt + OFF_BITS'(1);
                            if (r_cnt == OFF_LAST) begin
                                n_pend    = 1'b0;
                                tag_we    = 1'b1;
                                tag_wdata = {1'b1, r_acc_write, acc_tag};
                            end
                        end else begin
                            n_strobe         = 1'b1;
                            n_res.result_kind = dmwbc_pkg::RK_BAD;
                            n_res.last       = 1'b1;
                        end
                    end else if (i_req.kind == dmwbc_pkg::KIND_READ ||
                                 i_req.kind == dmwbc_pkg::KIND_WRITE) begin
                        n_acc_write = (i_req.kind == dmwbc_pkg::KIND_WRITE);
                        n_acc_addr  = i_req.address;
                        n_acc_word  = i_req.word;
                    end else begin
                        n_strobe         = 1'b1;
                        n_res.result_kind = dmwbc_pkg::RK_BAD;
                        n_res.last       = 1'b1;
                    end
                end
            end
            // Tag compare; hits finish here, misses invalidate the line.
            dmwbc_pkg::ST_LOOKUP: begin
                if (lk_hit) begin
                    n_strobe   = 1'b1;
                    n_res.hit  = 1'b1;
                    n_res.last = 1'b1;
                    if (r_acc_write) begin
                        dat_we            = 1'b1;
                        tag_we            = 1'b1;
                        tag_wdata         = {1'b1, 1'b1, acc_tag};
                        n_res.result_kind = dmwbc_pkg::RK_WRITE;
                    end else begin
                        n_res.result_kind = dmwbc_pkg::RK_READ;
                        n_res.result_word = dat_rdata;
                    end
                end else begin
                    tag_we    = 1'b1;
                    tag_wdata = {1'b0, 1'b0, ent_tag};
                    n_cnt     = '0;
                    n_vtag    = ent_tag;
                    dat_raddr = {acc_idx, {OFF_BITS{1'b0}}};
                    if (!(ent_valid && ent_dirty)) begin
                        n_pend                = 1'b1;
                        n_strobe              = 1'b1;
                        n_res.result_kind     = dmwbc_pkg::RK_FILL;
                        n_res.result_address  = {acc_tag, acc_idx, {OFF_BITS{1'b0}}, 2'b00};
                        n_res.last            = 1'b1;
                    end
                end
            end
            // Stream the dirty victim, one word per cycle.
            dmwbc_pkg::ST_WB: begin
                n_strobe             = 1'b1;
                n_res.result_kind    = dmwbc_pkg::RK_WB;
                n_res.result_address = {r_vtag, acc_idx, r_cnt, 2'b00};
                n_res.result_word    = dat_rdata;
                n_cnt                = r_cnt + OFF_BITS'(1);
                dat_raddr            = {acc_idx, n_cnt};
            end
            // Line-fill request after the write-back.
            dmwbc_pkg::ST_FREQ: begin
                n_pend               = 1'b1;
                n_strobe             = 1'b1;
                n_res.result_kind    = dmwbc_pkg::RK_FILL;
                n_res.result_address = {acc_tag, acc_idx, {OFF_BITS{1'b0}}, 2'b00};
                n_res.last           = 1'b1;
            end
            // Line is loaded: complete the pending access.
            dmwbc_pkg::ST_FIN: begin
                dat_raddr = {acc_idx, acc_off};
                if (r_acc_write) begin
                    dat_we            = 1'b1;
                    n_strobe          = 1'b1;
                    n_res.result_kind = dmwbc_pkg::RK_WRITE;
                    n_res.last        = 1'b1;
                end
            end
            // Read data of a completed read miss.
            dmwbc_pkg::ST_RESP: begin
                n_strobe          = 1'b1;
                n_res.result_kind = dmwbc_pkg::RK_READ;
                n_res.result_word = dat_rdata;
                n_res.last        = 1'b1;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmwbc_pkg::ST_CLEAR;
            r_pend      <= 1'b0;
            r_acc_write <= 1'b0;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_acc_write <= n_acc_write;
            r_cnt       <= n_cnt;
            r_clr       <= n_clr;
            r_strobe    <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_acc_addr <= n_acc_addr;
        r_acc_word <= n_acc_word;
        r_vtag     <= n_vtag;
        r_res      <= n_res;
    end

    assign busy         = (r_state != dmwbc_pkg::ST_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // A lookup never starts while a miss is outstanding.
    a_lookup_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmwbc_pkg::ST_LOOKUP) |-> !r_pend)
        else $error("lookup started while a miss is pending");

    // A fill request always leaves a miss pending.
    a_fill_sets_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.result_kind == dmwbc_pkg::RK_FILL) |-> r_pend)
        else $error("fill request without a pending miss");

    // Write-back beats come only out of the write-back state.
    a_wb_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.result_kind == dmwbc_pkg::RK_WB) |->
        ($past(r_state) == dmwbc_pkg::ST_WB))
        else $error("write-back beat outside the write-back state");

    // Only write-back beats leave last low.
    a_last_only_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_res.last) |-> (r_res.result_kind == dmwbc_pkg::RK_WB))
        else $error("non-final result that is not a write-back beat");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the direct-mapped write-back cache. A short table of
// directed requests opens the run, and a stream of random access and fill
// sequences follows. A software copy of the cache, not cycle accurate, works
// out every response that the table does not give. Each response from the block
// is compared field by field in arrival order.
// ============================================================================
module testbench;

    localparam int NUM_SETS       = 1024;
    localparam int WORDS_PER_LINE = 16;
    localparam int OFF_W          = $clog2(WORDS_PER_LINE);
    localparam int IDX_W          = $clog2(NUM_SETS);
    localparam int TAG_W          = 32 - 2 - OFF_W - IDX_W;

    localparam int          RESET_CYCLES = 4;
    localparam int          RANDOM_ITEMS = 480;
    localparam int          TAIL_CYCLES  = 40;
    localparam int          PRINT_LIMIT  = 40;
    localparam int unsigned CYCLE_LIMIT  = 400_000;

    // The request kind that the package leaves unnamed; the cache rejects it.
    localparam logic [1:0] KIND_RSVD = 2'd3;

    // Tags and indexes that the random accesses mostly stay within, so that
    // lines get hit, dirtied and evicted again and again.
    localparam logic [TAG_W-1:0] TAG_POOL [4] = '{16'h0000, 16'hFFFF, 16'hA5C3, 16'h3C5A};
    localparam logic [IDX_W-1:0] IDX_POOL [4] = '{10'h000, 10'h3FF, 10'h2AA, 10'h155};

    typedef struct {
        dmwbc_pkg::t_req req;
        bit              typed;
        dmwbc_pkg::t_res res;
    } t_directed_row;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    dmwbc_pkg::t_req i_req   = '0;
    logic            busy;
    logic            o_res_strobe;
    dmwbc_pkg::t_res o_res;

    // Software copy of the cache.
    logic [TAG_W-1:0] tag_store  [NUM_SETS];
    bit               valid_bits [NUM_SETS];
    bit               dirty_bits [NUM_SETS];
    logic [31:0]      word_store [NUM_SETS*WORDS_PER_LINE];
    bit               fill_active   = 1'b0;
    bit               fill_is_write = 1'b0;
    logic [31:0]      fill_address  = '0;
    logic [31:0]      held_word     = '0;
    int unsigned      fill_beats    = 0;

    // Responses of the latest request, and all responses still to arrive.
    dmwbc_pkg::t_res step_results[$];
    dmwbc_pkg::t_res cache_responses[$];

    t_directed_row directed_rows[$];

    int unsigned cycle_count    = 0;
    int unsigned fail_count     = 0;
    int unsigned results_seen   = 0;
    int unsigned requests_sent  = 0;
    int unsigned hit_count      = 0;
    int unsigned miss_count     = 0;
    int unsigned writeback_count = 0;
    int unsigned rejected_count = 0;
    int unsigned quiet_run      = 0;

    direct_mapped_writeback_cache #(
        .NUM_SETS       (NUM_SETS),
        .WORDS_PER_LINE (WORDS_PER_LINE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .busy         (busy),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic dmwbc_pkg::t_req make_request(logic [1:0] kind,
                                                     logic [31:0] address,
                                                     logic [31:0] word);
        dmwbc_pkg::t_req rq;
        rq.kind    = kind;
        rq.address = address;
        rq.word    = word;
        return rq;
    endfunction

    function automatic dmwbc_pkg::t_res make_result(logic [2:0] kind, logic [31:0] address,
                                                    logic [31:0] word, logic hit,
                                                    logic last);
        dmwbc_pkg::t_res rs;
        rs.result_kind    = kind;
        rs.result_address = address;
        rs.result_word    = word;
        rs.hit            = hit;
        rs.last           = last;
        return rs;
    endfunction

    // Applies one request to the software cache and lists the responses it
    // causes in step_results.
    function automatic void cache_access(input dmwbc_pkg::t_req rq);
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] off;
        logic [31:0]      victim;
        int unsigned      base;
        step_results.delete();

        // While a line fill is outstanding, only fill words are taken.
        if (fill_active) begin
            if (rq.kind != dmwbc_pkg::KIND_FILL) begin
                step_results.push_back(make_result(dmwbc_pkg::RK_BAD, '0, '0, 1'b0, 1'b1));
                rejected_count++;
                return;
            end
            tag  = fill_address[31 -: TAG_W];
            idx  = fill_address[2+OFF_W +: IDX_W];
            off  = fill_address[2 +: OFF_W];
            base = idx * WORDS_PER_LINE;
            word_store[base + fill_beats] = rq.word;
            fill_beats++;
            if (fill_beats < WORDS_PER_LINE) begin
                return;
            end
            // The last fill word installs the line and completes the access.
            tag_store[idx]  = tag;
            valid_bits[idx] = 1'b1;
            dirty_bits[idx] = 1'b0;
            fill_active     = 1'b0;
            fill_beats      = 0;
            if (fill_is_write) begin
                word_store[base + off] = held_word;
                dirty_bits[idx]        = 1'b1;
                step_results.push_back(make_result(dmwbc_pkg::RK_WRITE, '0, '0, 1'b0, 1'b1));
            end else begin
                step_results.push_back(make_result(dmwbc_pkg::RK_READ, '0,
                                                   word_store[base + off], 1'b0, 1'b1));
            end
            return;
        end

        if (rq.kind != dmwbc_pkg::KIND_READ && rq.kind != dmwbc_pkg::KIND_WRITE) begin
            step_results.push_back(make_result(dmwbc_pkg::RK_BAD, '0, '0, 1'b0, 1'b1));
            rejected_count++;
            return;
        end

        tag  = rq.address[31 -: TAG_W];
        idx  = rq.address[2+OFF_W +: IDX_W];
        off  = rq.address[2 +: OFF_W];
        base = idx * WORDS_PER_LINE;

        // Hit: serve the word from the line, or write it there.
        if (valid_bits[idx] && tag_store[idx] == tag) begin
            hit_count++;
            if (rq.kind == dmwbc_pkg::KIND_WRITE) begin
                word_store[base + off] = rq.word;
                dirty_bits[idx]        = 1'b1;
                step_results.push_back(make_result(dmwbc_pkg::RK_WRITE, '0, '0, 1'b1, 1'b1));
            end else begin
                step_results.push_back(make_result(dmwbc_pkg::RK_READ, '0,
                                                   word_store[base + off], 1'b1, 1'b1));
            end
            return;
        end

        // Miss: write back a dirty victim, then ask for the new line.
        miss_count++;
        if (valid_bits[idx] && dirty_bits[idx]) begin
            writeback_count++;
            victim = {tag_store[idx], idx, {(OFF_W+2){1'b0}}};
            for (int i = 0; i < WORDS_PER_LINE; i++) begin
                step_results.push_back(make_result(dmwbc_pkg::RK_WB, victim + 32'(4 * i),
                                                   word_store[base + i], 1'b0, 1'b0));
            end
        end
        step_results.push_back(make_result(dmwbc_pkg::RK_FILL,
                                           {tag, idx, {(OFF_W+2){1'b0}}}, '0,
                                           1'b0, 1'b1));
        valid_bits[idx] = 1'b0;
        dirty_bits[idx] = 1'b0;
        fill_active     = 1'b1;
        fill_is_write   = (rq.kind == dmwbc_pkg::KIND_WRITE);
        fill_address    = rq.address;
        held_word       = (rq.kind == dmwbc_pkg::KIND_WRITE) ? rq.word : '0;
        fill_beats      = 0;
    endfunction

    task automatic add_row(input dmwbc_pkg::t_req rq, input bit typed,
                           input dmwbc_pkg::t_res rs);
        t_directed_row row;
        row.req   = rq;
        row.typed = typed;
        row.res   = rs;
        directed_rows.push_back(row);
    endtask

    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("response %0d, %s is %h, should be %h",
                                   results_seen, name, got, want));
        end
    endtask

    // Presents one request, holds it until the cache takes it, records the
    // responses it should cause, then idles for a random gap that may be none.
    task automatic send_request(input dmwbc_pkg::t_req rq, input bit typed,
                                input dmwbc_pkg::t_res typed_res);
        int gap;
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy !== 1'b0);
        requests_sent++;
        cache_access(rq);
        if (typed) begin
            cache_responses.push_back(typed_res);
        end else begin
            foreach (step_results[k]) cache_responses.push_back(step_results[k]);
        end

        // Mostly random gaps, broken up now and then by back-to-back runs.
        if (quiet_run > 0) begin
            quiet_run--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) begin
                quiet_run = $urandom_range(8, 40);
            end
            gap = $urandom_range(0, 15);
        end
        if (gap != 0) begin
            start <= 1'b0;
            i_req <= make_request(2'($urandom), $urandom, $urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Compare every response from the cache with the oldest one outstanding.
    always @(posedge i_clk) begin : response_check
        dmwbc_pkg::t_res want;
        if (i_rst_n === 1'b1 && o_res_strobe !== 1'b0) begin
            if (o_res_strobe !== 1'b1) begin
                log_mismatch("response strobe is unknown");
            end else if (cache_responses.size() == 0) begin
                log_mismatch($sformatf("response %0d arrived with none outstanding, kind %0d",
                                       results_seen, o_res.result_kind));
                results_seen++;
            end else begin
                want = cache_responses.pop_front();
                check_field("kind",    32'(o_res.result_kind),    32'(want.result_kind));
                check_field("address", o_res.result_address,      want.result_address);
                check_field("word",    o_res.result_word,         want.result_word);
                check_field("hit",     32'(o_res.hit),            32'(want.hit));
                check_field("last",    32'(o_res.last),           32'(want.last));
                results_seen++;
            end
        end
    end

    // Hard stop in case the cache stalls or drops responses.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timed out after %0d cycles with %0d responses outstanding.",
                 cycle_count, cache_responses.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        dmwbc_pkg::t_req  rq;
        int unsigned      useful;
        logic [TAG_W-1:0] cur_tag;
        logic [IDX_W-1:0] cur_idx;
        logic [OFF_W+1:0] low_bits;
        logic [1:0]       noise_kind;
        useful  = 0;
        cur_tag = '0;
        cur_idx = '0;

        // Directed table: rejects, a write miss on an empty line and its fill,
        // hits on the new line, then a miss that evicts it while dirty.
        add_row(make_request(dmwbc_pkg::KIND_FILL, 32'h0000_0000, 32'hFFFF_FFFF), 1'b1,
                make_result(dmwbc_pkg::RK_BAD, '0, '0, 1'b0, 1'b1));
        add_row(make_request(KIND_RSVD, 32'hFFFF_FFFF, 32'h0000_0000), 1'b1,
                make_result(dmwbc_pkg::RK_BAD, '0, '0, 1'b0, 1'b1));
        add_row(make_request(dmwbc_pkg::KIND_WRITE, 32'h0000_003C, 32'hFFFF_FFFF), 1'b1,
                make_result(dmwbc_pkg::RK_FILL, 32'h0000_0000, '0, 1'b0, 1'b1));
        add_row(make_request(dmwbc_pkg::KIND_READ, 32'h0000_003C, 32'h0000_0000), 1'b1,
                make_result(dmwbc_pkg::RK_BAD, '0, '0, 1'b0, 1'b1));
        for (int i = 0; i < WORDS_PER_LINE; i++) begin
            add_row(make_request(dmwbc_pkg::KIND_FILL, 32'h0000_0000, 32'h0101_0101 * i),
                    1'b0, '0);
        end
        add_row(make_request(dmwbc_pkg::KIND_READ, 32'h0000_003C, 32'h0000_0000), 1'b1,
                make_result(dmwbc_pkg::RK_READ, '0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        add_row(make_request(dmwbc_pkg::KIND_WRITE, 32'h0000_0000, 32'h0000_0000), 1'b1,
                make_result(dmwbc_pkg::RK_WRITE, '0, '0, 1'b1, 1'b1));
        add_row(make_request(dmwbc_pkg::KIND_READ, 32'hFFFF_0000, 32'h0000_0000), 1'b0, '0);
        add_row(make_request(dmwbc_pkg::KIND_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                make_result(dmwbc_pkg::RK_BAD, '0, '0, 1'b0, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].res);
        end

        // Random part: well-formed access and fill sequences with a little
        // noise mixed in; rejected requests do not count toward the total.
        while (useful < RANDOM_ITEMS) begin
            if (fill_active) begin
                if ($urandom_range(0, 11) == 0) begin
                    noise_kind = 2'($urandom);
                    if (noise_kind == dmwbc_pkg::KIND_FILL) begin
                        noise_kind = KIND_RSVD;
                    end
                    rq = make_request(noise_kind, $urandom, $urandom);
                end else begin
                    rq = make_request(dmwbc_pkg::KIND_FILL, $urandom, $urandom);
                end
            end else if ($urandom_range(0, 11) == 0) begin
                rq = make_request($urandom_range(0, 1) ? dmwbc_pkg::KIND_FILL : KIND_RSVD,
                                  $urandom, $urandom);
            end else begin
                // Stay on the current line most of the time to get hits.
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        cur_tag = TAG_W'($urandom);
                        cur_idx = IDX_W'($urandom);
                    end else begin
                        cur_tag = TAG_POOL[$urandom_range(0, 3)];
                        cur_idx = IDX_POOL[$urandom_range(0, 3)];
                    end
                end
                low_bits = (OFF_W+2)'($urandom);
                rq = make_request($urandom_range(0, 1) ? dmwbc_pkg::KIND_WRITE
                                                       : dmwbc_pkg::KIND_READ,
                                  {cur_tag, cur_idx, low_bits}, $urandom);
            end
            send_request(rq, 1'b0, '0);
            if (step_results.size() == 0 ||
                step_results[0].result_kind != dmwbc_pkg::RK_BAD) begin
                useful++;
            end
        end
        start <= 1'b0;

        // Drain, then watch a while longer for stray responses.
        while (cache_responses.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d hits, %0d misses, %0d dirty evictions, %0d %s",
                 requests_sent, hit_count, miss_count, writeback_count, rejected_count,
                 "rejected.");
        $display("Compared %0d responses over %0d cycles, %0d mismatches.",
                 results_seen, cycle_count, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dmwbc_pkg.sv
rtl/core/dmwbc_ram.sv
rtl/core/direct_mapped_writeback_cache.sv
tb/sv/testbench.sv
